>>> rtl/pw4_pkg.sv
// Shared types and constants of the four-level page-table walker.
`timescale 1ns / 1ps
`default_nettype none

package pw4_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_OFFSET = 2'd1;
  localparam logic [1:0] CFG_ROOT   = 2'd2;

  // Translation modes (the unused code behaves as walk)
  localparam logic [1:0] MODE_IDENT  = 2'd0;
  localparam logic [1:0] MODE_OFFSET = 2'd1;

  // Input actions
  localparam logic ACT_WRITE = 1'b0;

  // Page kinds reported with a result
  localparam logic [1:0] KIND_4K   = 2'd0;
  localparam logic [1:0] KIND_2M   = 2'd1;
  localparam logic [1:0] KIND_1G   = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Entry bit positions
  localparam int PRESENT_BIT = 0;
  localparam int PS_BIT      = 7;

  // Walk level codes: level of the entry that the read returns
  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef struct packed {
    logic        action;
    logic [63:0] address;
    logic [63:0] write_data;
  } pw4_in_t;

  typedef struct packed {
    logic [63:0] phys_address;
    logic        fault;
    logic [1:0]  page_kind;
  } pw4_out_t;

  typedef struct packed {
    logic     done;
    pw4_out_t res;
  } pw4_step_t;

endpackage

`default_nettype wire

>>> rtl/page_walk_four_level_64.sv
// Top level of the four-level page-table walker with its internal table store.
`timescale 1ns / 1ps
`default_nettype none

// Translates 64-bit virtual addresses by identity, by subtracting a signed
// offset, or by a four-level page-table walk over an internal store of
// TABLE_WORDS 64-bit words, which write transactions fill. After reset the
// store is swept to zero, one word a cycle, through all TABLE_WORDS words;
// in_ready stays low during that sweep while configuration writes are taken
// as usual. Each transaction is handled on its own: a write, an identity or
// an offset transaction goes from acceptance straight to the result register,
// a walk after one dependent read of the synchronous store per level. The
// next transaction is taken only once the result has moved on to the output
// register. A finished result waits in the output register, and the next
// transaction is accepted while it waits.
// Configure only while the block is idle.
module page_walk_four_level_64 #(
  parameter int TABLE_WORDS = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pw4_pkg::pw4_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pw4_pkg::pw4_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [63:0]       cfg_wdata
);
  import pw4_pkg::*;

  localparam int AW = $clog2(TABLE_WORDS);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // Control and configuration
  logic [1:0]         state_r, state_nxt;
  logic [1:0]         level_r, level_nxt;
  logic [AW-1:0]      clr_cnt_r;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         mode_r;
  logic signed [31:0] offset_r;
  logic [63:0]        root_r;

  // Payload
  logic [63:0]        va_r, va_nxt;
  pw4_out_t           res_r, res_nxt;
  pw4_out_t           out_data_r, out_data_nxt;
  logic [63:0]        rd_data_r;

  // Table store
  logic [63:0]        table_mem [TABLE_WORDS];

  logic               accept;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [63:0]        wr_data;
  logic               wr_in_range;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [63:0]        off_diff;

  pw4_step_t          step;
  logic [AW-1:0]      next_word;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Root step on acceptance, entry check on every returned word after that
  pw4_step #(
    .TABLE_WORDS (TABLE_WORDS),
    .AW          (AW)
  ) u_step (
    .start     (accept),
    .level     (level_r),
    .entry     (accept ? {root_r[63:12], 12'd0} : rd_data_r),
    .va        (accept ? in_data.address : va_r),
    .step      (step),
    .next_word (next_word)
  );

  assign off_diff    = in_data.address - 64'(offset_r);
  assign wr_in_range = (in_data.address[63:3] < 61'(TABLE_WORDS));

  // Store port: sweep writes during clearing, then write transactions
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = 64'd0;
    if (state_r == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (accept && in_data.action == ACT_WRITE && wr_in_range) begin
      wr_en   = 1'b1;
      wr_addr = in_data.address[AW+2:3];
      wr_data = in_data.write_data;
    end
  end

  // Only one transaction is in flight, so a read never meets a write to the
  // same word in the same cycle
  always_comb begin
    rd_addr = next_word;
    rd_en   = 1'b0;
    if (accept && in_data.action != ACT_WRITE && mode_r != MODE_IDENT &&
        mode_r != MODE_OFFSET && !step.done) begin
      rd_en = 1'b1;
    end else if (state_r == ST_WALK && !step.done) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= table_mem[rd_addr];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    va_nxt        = va_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(TABLE_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          va_nxt    = in_data.address;
          state_nxt = ST_DONE;
          res_nxt   = '{phys_address: 64'd0, fault: 1'b0, page_kind: KIND_NONE};
          if (in_data.action == ACT_WRITE) begin
            state_nxt = ST_DONE;
          end else if (mode_r == MODE_IDENT) begin
            res_nxt.phys_address = in_data.address;
          end else if (mode_r == MODE_OFFSET) begin
            // negative result faults
            if (off_diff[63]) begin
              res_nxt.fault = 1'b1;
            end else begin
              res_nxt.phys_address = off_diff;
            end
          end else if (step.done) begin
            res_nxt = step.res;
          end else begin
            state_nxt = ST_WALK;
            level_nxt = LVL_PML4;
          end
        end
      end
      ST_WALK: begin
        if (step.done) begin
          res_nxt   = step.res;
          state_nxt = ST_DONE;
        end else begin
          level_nxt = level_r + 2'd1;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      level_r     <= LVL_PML4;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_IDENT;
      offset_r    <= '0;
      root_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:   mode_r   <= cfg_wdata[1:0];
          CFG_OFFSET: offset_r <= cfg_wdata[31:0];
          CFG_ROOT:   root_r   <= cfg_wdata;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    va_r       <= va_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/pw4_step.sv
// One walk step: checks an entry, finishes the walk or forms the next word index.
`timescale 1ns / 1ps
`default_nettype none

module pw4_step #(
  parameter int TABLE_WORDS = 4096,
  parameter int AW          = 12
) (
  input  wire logic                start,
  input  wire logic [1:0]          level,
  input  wire logic [63:0]         entry,
  input  wire logic [63:0]         va,
  output pw4_pkg::pw4_step_t       step,
  output logic      [AW-1:0]       next_word
);
  import pw4_pkg::*;

  logic [63:0] base;
  logic [8:0]  idx;
  logic [60:0] word;
  logic        present;
  logic        huge;
  logic        beyond;

  always_comb begin
    base    = start ? entry : entry;
    present = start | entry[PRESENT_BIT];
    huge    = entry[PS_BIT];
    if (start) begin
      idx = va[47:39];
    end else begin
      case (level)
        LVL_PML4: idx = va[38:30];
        LVL_PDPT: idx = va[29:21];
        default:  idx = va[20:12];
      endcase
    end
    // only base[63:12] is kept, so the word is base/8 + idx and never carries
    word      = {base[63:12], idx};
    beyond    = (word >= 61'(TABLE_WORDS));
    next_word = word[AW-1:0];
  end

  always_comb begin
    step.done             = 1'b1;
    step.res.phys_address = 64'd0;
    step.res.fault        = 1'b1;
    step.res.page_kind    = KIND_NONE;
    if (!present) begin
      step.done = 1'b1;
    end else if (!start && level == LVL_PDPT && huge) begin
      step.res.phys_address = {12'd0, entry[51:30], va[29:0]};
      step.res.fault        = 1'b0;
      step.res.page_kind    = KIND_1G;
    end else if (!start && level == LVL_PD && huge) begin
      step.res.phys_address = {entry[63:21], va[20:0]};
      step.res.fault        = 1'b0;
      step.res.page_kind    = KIND_2M;
    end else if (!start && level == LVL_PT) begin
      step.res.phys_address = {entry[63:12], va[11:0]};
      step.res.fault        = 1'b0;
      step.res.page_kind    = KIND_4K;
    end else if (beyond) begin
      step.done = 1'b1;
    end else begin
      step.done = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pw4_checker.sv
// Port-level checks of the page-table walker and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pw4_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire pw4_pkg::pw4_out_t out_data
);
  import pw4_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only one transaction in flight: no acceptance right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted while another is in flight");

  // A fault carries a zero address and no page kind
  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault |->
      out_data.phys_address == 64'd0 && out_data.page_kind == KIND_NONE)
    else $error("fault result with address or page kind");

  // A 1 GiB frame never reaches above bit 51
  a_gib_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.page_kind == KIND_1G |->
      out_data.phys_address[63:52] == 12'd0 && !out_data.fault)
    else $error("1 GiB translation out of range");

endmodule

bind page_walk_four_level_64 pw4_checker u_pw4_checker (.*);

`default_nettype wire

>>> tb/tb_page_walk_four_level_64.sv
// Self-checking testbench of the four-level page-table walker.
`timescale 1ns / 1ps

module tb_page_walk_four_level_64;
  import pw4_pkg::*;

  localparam int TABLE_WORDS     = 4096;
  localparam int WATCHDOG_LIMIT  = 20000;  // covers the clearing sweep several times over
  localparam int STALL_CYCLES    = 300;    // long receiver hold-off
  localparam int SETTLE_CYCLES   = 10;
  localparam int PHASE_ITEMS     = 150;
  localparam int NUM_PHASES      = 8;

  // Codes the package leaves unnamed
  localparam logic [1:0] MODE_WALK  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, walks as well
  localparam logic       ACT_XLATE  = 1'b1;

  // Entry and address masks of the x86_64 walk
  localparam logic [63:0] BASE_MASK   = 64'hFFFF_FFFF_FFFF_F000;
  localparam logic [63:0] GIB_MASK    = 64'h000F_FFFF_C000_0000;
  localparam logic [63:0] MIB_MASK    = 64'hFFFF_FFFF_FFE0_0000;
  localparam logic [63:0] GIB_OFF     = 64'h0000_0000_3FFF_FFFF;
  localparam logic [63:0] MIB_OFF     = 64'h0000_0000_001F_FFFF;
  localparam logic [63:0] PG_OFS_MASK = 64'h0000_0000_0000_0FFF;

  // Clock, reset and block ports; every input starts at a known value
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  pw4_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pw4_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_MODE;
  logic [63:0] cfg_wdata = '0;

  // Shadow of the block: table store and registers
  logic [63:0] pt_shadow [TABLE_WORDS];
  logic [1:0]  mode_sh   = MODE_IDENT;
  logic [31:0] offset_sh = '0;
  logic [63:0] root_sh   = '0;

  // Transactions waiting to be offered, and results still owed by the block
  pw4_in_t  pending_q [$];
  pw4_out_t result_q  [$];

  int offered_cnt  = 0;   // transactions put on the input channel
  int taken_cnt    = 0;   // transactions accepted by the block
  int drained_cnt  = 0;   // results accepted from the block
  int queued_cnt   = 0;
  int err_cnt      = 0;
  int quiet_cycles = 0;
  int write_cnt    = 0;
  int fault_cnt    = 0;
  int kind_cnt [4] = '{0, 0, 0, 0};

  // Idling control shared with the driver and receiver
  logic idle_on      = 1'b1;
  int   stall_reqs   = 0;
  int   stall_served = 0;
  int   send_gap     = 0;
  int   recv_gap     = 0;
  int   stall_left   = 0;
  int   seen_out     = 0;

  page_walk_four_level_64 #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Read one table entry at base + idx*8; true only when it lies in the store
  // and is present.
  function automatic logic fetch_entry(input logic [63:0] base, input logic [8:0] idx,
                                       output logic [63:0] ent);
    logic [63:0] byte_addr;
    byte_addr = base + {52'd0, idx, 3'd0};
    ent = '0;
    if ((byte_addr >> 3) >= 64'(TABLE_WORDS)) return 1'b0;
    ent = pt_shadow[int'(byte_addr >> 3)];
    return ent[PRESENT_BIT];
  endfunction

  // Work out the result a transaction produces; a write updates the shadow store.
  function automatic pw4_out_t predict_result(input pw4_in_t t);
    pw4_out_t    r;
    logic [63:0] ent;
    logic [63:0] diff;
    logic        ok;
    r.phys_address = '0;
    r.fault        = 1'b0;
    r.page_kind    = KIND_NONE;
    if (t.action == ACT_WRITE) begin
      if ((t.address >> 3) < 64'(TABLE_WORDS)) pt_shadow[int'(t.address >> 3)] = t.write_data;
    end else if (mode_sh == MODE_IDENT) begin
      r.phys_address = t.address;
    end else if (mode_sh == MODE_OFFSET) begin
      diff = t.address - {{32{offset_sh[31]}}, offset_sh};
      if (diff[63]) r.fault = 1'b1;
      else r.phys_address = diff;
    end else begin
      ok = fetch_entry(root_sh & BASE_MASK, t.address[47:39], ent);
      if (ok) ok = fetch_entry(ent & BASE_MASK, t.address[38:30], ent);
      if (ok && ent[PS_BIT]) begin
        r.phys_address = (ent & GIB_MASK) + (t.address & GIB_OFF);
        r.page_kind    = KIND_1G;
      end else if (ok) begin
        ok = fetch_entry(ent & BASE_MASK, t.address[29:21], ent);
        if (ok && ent[PS_BIT]) begin
          r.phys_address = (ent & MIB_MASK) + (t.address & MIB_OFF);
          r.page_kind    = KIND_2M;
        end else if (ok) begin
          ok = fetch_entry(ent & BASE_MASK, t.address[20:12], ent);
          if (ok) begin
            r.phys_address = (ent & BASE_MASK) + (t.address & PG_OFS_MASK);
            r.page_kind    = KIND_4K;
          end
        end
      end
      if (!ok) begin
        r.phys_address = '0;
        r.fault        = 1'b1;
        r.page_kind    = KIND_NONE;
      end
    end
    return r;
  endfunction

  // Driver: offer the next pending transaction at the falling edge, hold it
  // until the block takes it, then wait out the drawn gap.
  always @(negedge clk) begin : drive
    logic nxt_valid;
    nxt_valid = in_valid;
    if (rst_n) begin
      if (in_valid && (taken_cnt == offered_cnt)) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0) begin
          in_data <= pending_q.pop_front();
          offered_cnt++;
          nxt_valid = 1'b1;
          send_gap  = idle_on ? $urandom_range(0, 11) : 0;
        end
      end
    end
    in_valid <= nxt_valid;
  end

  // Receiver: drop ready for a drawn gap after each result, and for a long
  // stretch whenever the stimulus asks for a hold-off.
  always @(negedge clk) begin : receive
    logic rdy;
    if (drained_cnt != seen_out) begin
      seen_out = drained_cnt;
      recv_gap = idle_on ? $urandom_range(0, 11) : 0;
    end
    if (stall_served != stall_reqs) begin
      stall_served = stall_reqs;
      stall_left   = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_ready <= rdy;
  end

  // Monitor: at each rising edge predict accepted transactions, check
  // accepted results in order, and keep the watchdog running.
  always @(posedge clk) begin : monitor
    pw4_out_t want;
    logic     active;
    if (rst_n) begin
      active = cfg_we;
      if (in_valid && in_ready) begin
        result_q.push_back(predict_result(in_data));
        if (in_data.action == ACT_WRITE) write_cnt++;
        taken_cnt++;
        active = 1'b1;
      end
      if (out_valid && out_ready) begin
        drained_cnt++;
        active = 1'b1;
        if (result_q.size() == 0) begin
          $error("result with no transaction outstanding: %h", out_data);
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          if (out_data.phys_address !== want.phys_address) begin
            $error("phys_address: expected %h, got %h", want.phys_address,
                   out_data.phys_address);
            err_cnt++;
          end
          if (out_data.fault !== want.fault) begin
            $error("fault: expected %b, got %b", want.fault, out_data.fault);
            err_cnt++;
          end
          if (out_data.page_kind !== want.page_kind) begin
            $error("page_kind: expected %0d, got %0d", want.page_kind, out_data.page_kind);
            err_cnt++;
          end
          if (want.fault) fault_cnt++;
          else kind_cnt[want.page_kind]++;
        end
      end
      quiet_cycles = active ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, result_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Write one register and mirror it in the shadow; the task does not wait for the block to be idle.
  task automatic set_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MODE:   mode_sh   = val[1:0];
      CFG_OFFSET: offset_sh = val[31:0];
      CFG_ROOT:   root_sh   = val;
      default: ;
    endcase
  endtask

  task automatic push_write(input logic [63:0] addr, input logic [63:0] data);
    pw4_in_t t;
    t.action     = ACT_WRITE;
    t.address    = addr;
    t.write_data = data;
    pending_q.push_back(t);
    queued_cnt++;
  endtask

  // Translation transactions carry junk in write_data; the block must ignore it.
  task automatic push_xlate(input logic [63:0] va);
    pw4_in_t t;
    t.action     = ACT_XLATE;
    t.address    = va;
    t.write_data = rand64();
    pending_q.push_back(t);
    queued_cnt++;
  endtask

  // Hold the sender until every transaction is accepted and every result is
  // back, then let the walk pipeline settle.
  task automatic wait_idle();
    while (pending_q.size() != 0 || taken_cnt != offered_cnt || result_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] va_of(input logic [8:0] i4, input logic [8:0] i3,
                                        input logic [8:0] i2, input logic [8:0] i1,
                                        input logic [11:0] pofs);
    return {16'h0000, i4, i3, i2, i1, pofs};
  endfunction

  // Build one table chain from the root down to a random leaf size, writing
  // each level's entry, then translate addresses that follow it. Now and then
  // break the chain: clear present, point past the store, or skip the write.
  task automatic push_walk_chain();
    logic [63:0] va;
    logic [63:0] xva;
    logic [63:0] tbl;
    logic [63:0] ent;
    logic [63:0] eaddr;
    int          leaf;
    int          lvl;
    int          broken_at;
    int          how;
    int          n_xl;
    va        = rand64();
    leaf      = $urandom_range(int'(LVL_PDPT), int'(LVL_PT));
    broken_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, leaf) : -1;
    tbl       = root_sh & BASE_MASK;
    for (lvl = 0; lvl <= leaf; lvl++) begin
      eaddr = tbl + {52'd0, va[47 - 9*lvl -: 9], 3'd0};
      if (lvl < leaf) begin
        ent = (rand64() & PG_OFS_MASK) | (64'($urandom_range(0, 7)) << 12);
        ent[PRESENT_BIT] = 1'b1;
        if (lvl != 0) ent[PS_BIT] = 1'b0;
      end else begin
        ent = rand64();
        ent[PRESENT_BIT] = 1'b1;
        ent[PS_BIT]      = (lvl != int'(LVL_PT));
      end
      how = (lvl == broken_at) ? $urandom_range(1, 3) : 0;
      if (how == 1) ent[PRESENT_BIT] = 1'b0;
      if (how == 2) ent[47:32] = 16'($urandom_range(1, 16'hFFFF));
      if (how != 3) push_write(eaddr | 64'($urandom_range(0, 7)), ent);
      tbl = ent & BASE_MASK;
    end
    n_xl = $urandom_range(1, 3);
    repeat (n_xl) begin
      xva = va;
      xva[63:48] = 16'($urandom);
      if (leaf == int'(LVL_PDPT)) xva[29:0] = 30'($urandom);
      else if (leaf == int'(LVL_PD)) xva[20:0] = 21'($urandom);
      else xva[11:0] = 12'($urandom);
      push_xlate(xva);
    end
  endtask

  // One random phase in the current mode; walk phases are mostly chains,
  // offset phases aim around the sign boundary of the difference.
  task automatic push_phase();
    int          start;
    int          pick;
    logic [63:0] soff;
    start = queued_cnt;
    soff  = {{32{offset_sh[31]}}, offset_sh};
    while (queued_cnt - start < PHASE_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        if ($urandom_range(0, 1)) push_write(64'($urandom_range(0, 16'h7FFF)), rand64());
        else push_write(rand64(), rand64());
      end else if (pick == 1) begin
        push_xlate(rand64());
      end else if (mode_sh == MODE_WALK || mode_sh == MODE_SPARE) begin
        push_walk_chain();
      end else if (mode_sh == MODE_OFFSET) begin
        case ($urandom_range(0, 2))
          0: push_xlate(soff + 64'($urandom_range(0, 64)) - 64'd32);
          1: push_xlate(soff + 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 64)) - 64'd32);
          default: push_xlate(rand64());
        endcase
      end else begin
        push_xlate(rand64());
      end
    end
  endtask

  initial begin : stimulus
    logic [1:0] phase_mode [NUM_PHASES];
    int         ph;
    phase_mode = '{MODE_WALK, MODE_OFFSET, MODE_WALK, MODE_IDENT,
                   MODE_WALK, MODE_SPARE, MODE_OFFSET, MODE_WALK};
    for (int i = 0; i < TABLE_WORDS; i++) pt_shadow[i] = '0;

    // Hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers are taken during the clearing sweep
    set_reg(CFG_MODE, {62'd0, MODE_IDENT});
    set_reg(CFG_OFFSET, 64'd0);
    set_reg(CFG_ROOT, 64'd0);

    // Directed: identity at the address extremes, and writes past the store and to its last word
    push_xlate(64'd0);
    push_xlate('1);
    push_write(64'hFFFF_FFFF_FFFF_FFF8, '1);
    push_write(64'h0000_0000_0000_8000, 64'h0000_0000_0000_1001);
    push_write(64'h0000_0000_0000_7FFF, '1);
    wait_idle();

    // Offset at its positive extreme: small addresses go negative
    set_reg(CFG_MODE, {62'd0, MODE_OFFSET});
    set_reg(CFG_OFFSET, 64'h0000_0000_7FFF_FFFF);
    push_xlate(64'd0);
    push_xlate(64'h0000_0000_7FFF_FFFF);
    push_xlate('1);
    wait_idle();

    // Offset at its negative extreme: adds 2^31, overflowing into bit 63
    set_reg(CFG_OFFSET, 64'h0000_0000_8000_0000);
    push_xlate(64'd0);
    push_xlate(64'h7FFF_FFFF_FFFF_FFFF);
    wait_idle();

    // Walk with the root far beyond the store
    set_reg(CFG_MODE, {62'd0, MODE_WALK});
    set_reg(CFG_ROOT, 64'hFFFF_FFFF_FFFF_F123);
    push_xlate(64'd0);
    wait_idle();

    // Hand-built tables: 1 GiB, 2 MiB and 4 KiB leaves, a missing entry and
    // a pointer past the store; the root's low bits must be ignored
    set_reg(CFG_ROOT, 64'h0000_0000_0000_1FFF);
    push_write(64'h1005, 64'h0000_0000_0000_2063);
    push_write(64'h2000, 64'hFFFF_FFFF_C000_0081);
    push_write(64'h2009, 64'h0000_0000_0000_3001);
    push_write(64'h2012, 64'hFFFF_0000_0000_0001);
    push_write(64'h3000, 64'hFFFF_FFFF_FFE0_0081);
    push_write(64'h300F, 64'h0000_0000_0000_4001);
    push_write(64'h4000, 64'hFFFF_FFFF_FFFF_F001);
    push_write(64'h4008, 64'hFFFF_FFFF_FFFF_F000);
    push_xlate(va_of(9'd0, 9'd0, 9'h1FF, 9'h1FF, 12'hFFF));
    push_xlate(va_of(9'd0, 9'd1, 9'd0, 9'h1AB, 12'h123));
    push_xlate(va_of(9'd0, 9'd1, 9'd1, 9'd0, 12'hABC));
    push_xlate(va_of(9'd0, 9'd1, 9'd1, 9'd1, 12'h000));
    push_xlate(va_of(9'd1, 9'd0, 9'd0, 9'd0, 12'h000));
    push_xlate(va_of(9'd0, 9'd2, 9'd0, 9'd0, 12'h000));
    wait_idle();

    // The spare mode code walks as well
    set_reg(CFG_MODE, {62'd0, MODE_SPARE});
    push_xlate(va_of(9'd0, 9'd1, 9'd1, 9'd0, 12'h555) | 64'hFFFF_0000_0000_0000);
    wait_idle();

    // Random phases, each with its own settings; the store carries over
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      idle_on = (ph % 3 != 2);
      set_reg(CFG_MODE, {62'd0, phase_mode[ph]});
      set_reg(CFG_OFFSET, (ph == 6) ? 64'h0000_0000_8000_0000 : 64'($urandom));
      set_reg(CFG_ROOT, (ph == 0) ? 64'd0
                                   : (64'($urandom_range(0, 7)) << 12) | 64'($urandom_range(0, 12'hFFF)));
      push_phase();
      // Hold the receiver off while the sender keeps offering, so the block
      // backs up and stalls its input
      if (ph == 4) stall_reqs++;
      wait_idle();
    end

    $display("Covered %0d transactions: %0d table writes, %0d translations, %0d faults",
             taken_cnt, write_cnt, taken_cnt - write_cnt, fault_cnt);
    $display("Pages hit: %0d of 1 GiB, %0d of 2 MiB, %0d of 4 KiB; %0d untranslated",
             kind_cnt[KIND_1G], kind_cnt[KIND_2M], kind_cnt[KIND_4K], kind_cnt[KIND_NONE]);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
